/* rtl/core/pfar_pkg.sv */
// Shared constants, register map and pipeline types for the phase-field residual core.
package pfar_pkg;

    localparam int DATA_W            = 32;
    localparam int DIMENSION_DEF     = 3;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int SQRT_STAGES       = 32;
    localparam int TAIL_STAGES       = 13;
    localparam int CFG_ADDR_W        = 4;

    localparam logic [31:0] EPS_RST = 32'd0;
    localparam logic [30:0] MC_RST  = 31'd16777216;
    localparam logic [30:0] MN_RST  = 31'd16777216;
    localparam logic [30:0] DT_RST  = 31'd1677;

    typedef enum logic [1:0] {
        REG_ANISO = 2'd0,
        REG_CMOB  = 2'd1,
        REG_NMOB  = 2'd2,
        REG_DT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0]       c;
        logic [31:0]       n;
        logic [2:0][31:0]  cx;
        logic [2:0][31:0]  g;
    } item_t;

    typedef struct packed {
        logic [31:0]       c;
        logic [31:0]       n;
        logic [2:0][31:0]  cx;
        logic [2:0][31:0]  g;
        logic [31:0]       nrm;
        logic [2:0][31:0]  m;
        logic [2:0][31:0]  m2;
        logic [2:0][31:0]  m3;
        logic [2:0][31:0]  m4;
        logic [2:0][31:0]  dgq;
        logic [33:0]       s4;
        logic [2:0][31:0]  dg;
        logic [31:0]       t;
        logic [2:0][31:0]  md;
        logic [31:0]       gq;
        logic [31:0]       dot;
        logic [31:0]       gamma;
        logic [2:0][31:0]  mdot;
        logic [2:0][31:0]  gg;
        logic [2:0][31:0]  a;
        logic [2:0][31:0]  an1;
        logic [2:0][31:0]  s;
        logic [2:0][31:0]  an;
        logic [2:0][31:0]  r;
        logic [2:0][31:0]  of;
        logic [31:0]       cm1;
        logic [31:0]       cc;
        logic [31:0]       n2;
        logic [31:0]       fac;
        logic [31:0]       fa;
        logic [31:0]       cm;
        logic [31:0]       n3;
        logic [31:0]       fbc;
        logic [31:0]       hn;
        logic [31:0]       fb;
        logic [31:0]       h;
        logic [31:0]       dfc;
        logic [2:0][31:0]  ghn;
        logic [31:0]       omh;
        logic [31:0]       wb;
        logic [31:0]       fbfa;
        logic [2:0][31:0]  ghd;
        logic [31:0]       wa;
        logic [31:0]       t1;
        logic [31:0]       w;
        logic [31:0]       t2;
        logic [2:0][31:0]  cxw;
        logic [31:0]       ov;
        logic [2:0][31:0]  cf;
        logic [2:0][31:0]  cr;
        logic [2:0][31:0]  cfo;
    } tail_t;

endpackage

/* rtl/core/pfar_sqrt.sv */
// Pipelined 64-bit integer square root, one result bit per stage.
module pfar_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    logic [63:0] v_reg [0:pfar_pkg::SQRT_STAGES-1];
    logic [63:0] r_reg [0:pfar_pkg::SQRT_STAGES-1];

    for (genvar k = 0; k < pfar_pkg::SQRT_STAGES; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] v_in;
        logic [63:0] r_in;
        logic [64:0] sum;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign v_in = rad;
            assign r_in = '0;
        end
        else
        begin : g_next
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign sum = {1'b0, r_in} + {1'b0, BIT};
        assign ge  = {1'b0, v_in} >= sum;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= ge ? (v_in - sum[63:0]) : v_in;
                r_reg[k] <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
            end
        end
    end

    assign root = r_reg[pfar_pkg::SQRT_STAGES-1][31:0];

endmodule

/* rtl/core/pfar_div.sv */
// Pipelined restoring divider: signed numerator scaled by 2^FRAC_BITS over unsigned norm.
module pfar_div #(
    parameter int FRAC_BITS = pfar_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);

    localparam int QW = FRAC_BITS + 1;

    logic [31:0]   rem_reg  [0:FRAC_BITS];
    logic [QW-1:0] q_reg    [0:FRAC_BITS];
    logic [31:0]   den_reg  [0:FRAC_BITS];
    logic          neg_reg  [0:FRAC_BITS];
    logic          zero_reg [0:FRAC_BITS];
    logic [31:0]   quo_reg;

    for (genvar j = 0; j <= FRAC_BITS; j++)
    begin : g_stage
        logic [32:0]   r_in;
        logic [31:0]   d_in;
        logic [QW-1:0] q_in;
        logic          neg_in;
        logic          zero_in;
        logic          ge;
        logic [32:0]   diff;

        if (j == 0)
        begin : g_first
            assign r_in    = {1'b0, num[31] ? (32'd0 - num) : num};
            assign d_in    = den;
            assign q_in    = '0;
            assign neg_in  = num[31];
            assign zero_in = (den == 32'd0);
        end
        else
        begin : g_next
            assign r_in    = {rem_reg[j-1], 1'b0};
            assign d_in    = den_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign zero_in = zero_reg[j-1];
        end

        assign ge   = r_in >= {1'b0, d_in};
        assign diff = r_in - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? diff[31:0] : r_in[31:0];
                q_reg[j]    <= {q_in[QW-2:0], ge};
                den_reg[j]  <= d_in;
                neg_reg[j]  <= neg_in;
                zero_reg[j] <= zero_in;
            end
        end
    end

    logic [31:0] mag;
    assign mag = {{(32-QW){1'b0}}, q_reg[FRAC_BITS]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[FRAC_BITS])
            begin
                quo_reg <= '0;
            end
            else
            begin
                quo_reg <= neg_reg[FRAC_BITS] ? (32'd0 - mag) : mag;
            end
        end
    end

    assign quo = quo_reg;

endmodule

/* rtl/core/phase_field_anisotropic_residual_core.sv */
// Datapath behind the input register: 2 squaring stages, the 32-stage square root, the
// FRACTION_BITS + 2 stage divider lanes that form the unit normal (Q8.24 by default)
// and 13 residual tail stages.
// Throughput: one item per cycle; every stage is registered and holds only on a stall.
// When a result waits on out_ready the whole pipeline holds and in_ready drops.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the register
// defaults: anisotropy 0, both mobilities 1.0, time step 1677.
module phase_field_anisotropic_residual_core #(
    parameter int DIMENSION     = pfar_pkg::DIMENSION_DEF,
    parameter int FRACTION_BITS = pfar_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfar_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [31:0]                     conc,
    input  logic [31:0]                     conc_grad_x,
    input  logic [31:0]                     conc_grad_y,
    input  logic [31:0]                     conc_grad_z,
    input  logic [31:0]                     order,
    input  logic [31:0]                     order_grad_x,
    input  logic [31:0]                     order_grad_y,
    input  logic [31:0]                     order_grad_z,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [31:0]                     conc_value_term,
    output logic [31:0]                     conc_flux_x,
    output logic [31:0]                     conc_flux_y,
    output logic [31:0]                     conc_flux_z,
    output logic [31:0]                     order_value_term,
    output logic [31:0]                     order_flux_x,
    output logic [31:0]                     order_flux_y,
    output logic [31:0]                     order_flux_z
);

    localparam int DIMS    = (DIMENSION == 2) ? 2 : 3;
    localparam int DIV_LAT = FRACTION_BITS + 2;
    localparam int S_RT    = 2 + pfar_pkg::SQRT_STAGES;
    localparam int S_M     = S_RT + DIV_LAT;
    localparam int LAST    = S_M + pfar_pkg::TAIL_STAGES;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRACTION_BITS;
    localparam logic [31:0]        Q16 = 32'(ONE >>> 4);

    // fixed-point helpers
    function automatic logic signed [63:0] s64(input logic [31:0] x);
        return 64'($signed(x));
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (x < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = s64(a) * s64(b);
        return sat32(p >>> FRACTION_BITS);
    endfunction

    function automatic pfar_pkg::tail_t tail_step(
        input int               k,
        input pfar_pkg::tail_t  p,
        input logic [31:0]      eps,
        input logic [31:0]      dtmn,
        input logic [31:0]      mcdt
    );
        pfar_pkg::tail_t q;
        logic [31:0]     nrms;
        q    = p;
        nrms = p.nrm[31] ? 32'h7FFF_FFFF : p.nrm;
        case (k)
            1:
            begin
                for (int i = 0; i < 3; i++)
                    q.m2[i] = qmul(p.m[i], p.m[i]);
            end
            2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q.m3[i] = qmul(p.m2[i], p.m[i]);
                    q.m4[i] = qmul(p.m2[i], p.m2[i]);
                end
            end
            3:
            begin
                for (int i = 0; i < 3; i++)
                    q.dgq[i] = qmul(eps, p.m3[i]);
                q.s4 = 34'(s64(p.m4[0]) + s64(p.m4[1]) + s64(p.m4[2]));
            end
            4:
            begin
                for (int i = 0; i < 3; i++)
                    q.dg[i] = sat32(64'sd16 * s64(p.dgq[i]));
                q.t   = sat32(64'sd4 * 64'($signed(p.s4)) - 64'sd3 * ONE);
                q.cm1 = sat32(s64(p.c) - ONE);
                q.cc  = qmul(p.c, p.c);
                q.n2  = qmul(p.n, p.n);
                q.fac = 32'($signed(p.c) >>> 4);
            end
            5:
            begin
                for (int i = 0; i < 3; i++)
                    q.md[i] = qmul(p.m[i], p.dg[i]);
                q.gq  = qmul(eps, p.t);
                q.fa  = 32'($signed(p.cc) >>> 5);
                q.cm  = qmul(p.cm1, p.cm1);
                q.n3  = qmul(p.n2, p.n);
                q.fbc = 32'($signed(p.cm1) >>> 4);
                q.hn  = sat32(64'sd6 * (s64(p.n) - s64(p.n2)));
            end
            6:
            begin
                q.dot   = sat32(s64(p.md[0]) + s64(p.md[1]) + s64(p.md[2]));
                q.gamma = sat32(ONE + s64(p.gq));
                q.fb    = 32'($signed(p.cm) >>> 5);
                q.h     = sat32(64'sd3 * s64(p.n2) - 64'sd2 * s64(p.n3));
                q.dfc   = sat32(s64(p.fbc) - s64(p.fac));
                for (int i = 0; i < 3; i++)
                    q.ghn[i] = qmul(p.g[i], p.hn);
            end
            7:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q.mdot[i] = qmul(p.m[i], p.dot);
                    q.gg[i]   = qmul(p.gamma, p.g[i]);
                    q.ghd[i]  = qmul(p.ghn[i], p.dfc);
                end
                q.omh  = sat32(ONE - s64(p.h));
                q.wb   = qmul(p.h, Q16);
                q.fbfa = sat32(s64(p.fb) - s64(p.fa));
            end
            8:
            begin
                for (int i = 0; i < 3; i++)
                    q.a[i] = sat32(s64(p.dg[i]) - s64(p.mdot[i]));
                q.wa = qmul(p.omh, Q16);
                q.t1 = qmul(dtmn, p.fbfa);
            end
            9:
            begin
                for (int i = 0; i < 3; i++)
                    q.an1[i] = qmul(p.a[i], nrms);
                q.w  = sat32(s64(p.wa) + s64(p.wb));
                q.t2 = qmul(p.t1, p.hn);
            end
            10:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q.s[i]   = sat32(s64(p.an1[i]) + s64(p.gg[i]));
                    q.cxw[i] = qmul(p.cx[i], p.w);
                end
                q.ov = sat32(s64(p.n) - s64(p.t2));
            end
            11:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q.an[i] = qmul(p.gamma, p.s[i]);
                    q.cf[i] = sat32(s64(p.cxw[i]) + s64(p.ghd[i]));
                end
            end
            12:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q.r[i]  = qmul(dtmn, p.an[i]);
                    q.cr[i] = qmul(mcdt, p.cf[i]);
                end
            end
            13:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q.of[i]  = (i < DIMS) ? sat32(-s64(p.r[i]))  : 32'd0;
                    q.cfo[i] = (i < DIMS) ? sat32(-s64(p.cr[i])) : 32'd0;
                end
            end
            default:
            begin
                q = p;
            end
        endcase
        return q;
    endfunction

    // configuration registers
    logic [31:0] eps_reg;
    logic [30:0] mc_reg;
    logic [30:0] mn_reg;
    logic [30:0] dt_reg;
    logic [31:0] dtmn_reg;
    logic [31:0] mcdt_reg;
    logic        cfg_wr;
    pfar_pkg::cfg_reg_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = pfar_pkg::cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= pfar_pkg::EPS_RST;
            mc_reg  <= pfar_pkg::MC_RST;
            mn_reg  <= pfar_pkg::MN_RST;
            dt_reg  <= pfar_pkg::DT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                pfar_pkg::REG_ANISO: eps_reg <= pwdata;
                pfar_pkg::REG_CMOB:  mc_reg  <= pwdata[30:0];
                pfar_pkg::REG_NMOB:  mn_reg  <= pwdata[30:0];
                pfar_pkg::REG_DT:    dt_reg  <= pwdata[30:0];
                default:             eps_reg <= eps_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            pfar_pkg::REG_ANISO: prdata = eps_reg;
            pfar_pkg::REG_CMOB:  prdata = {1'b0, mc_reg};
            pfar_pkg::REG_NMOB:  prdata = {1'b0, mn_reg};
            pfar_pkg::REG_DT:    prdata = {1'b0, dt_reg};
            default:             prdata = '0;
        endcase
    end

    // mobility-time products: the user keeps them stable while items flow; not enforced here
    always_ff @(posedge clk)
    begin
        dtmn_reg <= qmul({1'b0, dt_reg}, {1'b0, mn_reg});
        mcdt_reg <= qmul({1'b0, mc_reg}, {1'b0, dt_reg});
    end

    // pipeline control
    logic [LAST:0] v_reg;
    logic          adv;

    assign adv       = !v_reg[LAST] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAST-1:0], in_valid};
        end
    end

    // item carry line up to the normal
    pfar_pkg::item_t itm_in;
    pfar_pkg::item_t itm_reg [0:S_M];

    always_comb
    begin
        itm_in.c     = conc;
        itm_in.n     = order;
        itm_in.cx[0] = conc_grad_x;
        itm_in.cx[1] = conc_grad_y;
        itm_in.cx[2] = (DIMENSION == 2) ? 32'd0 : conc_grad_z;
        itm_in.g[0]  = order_grad_x;
        itm_in.g[1]  = order_grad_y;
        itm_in.g[2]  = (DIMENSION == 2) ? 32'd0 : order_grad_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            itm_reg[0] <= itm_in;
            for (int k = 1; k <= S_M; k++)
                itm_reg[k] <= itm_reg[k-1];
        end
    end

    // squared gradient magnitude
    logic [2:0][63:0] sq_reg;
    logic [63:0]      ss_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= 64'(s64(itm_reg[0].g[i]) * s64(itm_reg[0].g[i]));
            ss_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    logic [31:0] root;

    pfar_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (ss_reg),
        .root (root)
    );

    logic [31:0] nrm_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nrm_reg[0] <= root;
            for (int k = 1; k < DIV_LAT; k++)
                nrm_reg[k] <= nrm_reg[k-1];
        end
    end

    logic [2:0][31:0] m_lane;

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        pfar_div #(
            .FRAC_BITS (FRACTION_BITS)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (itm_reg[S_RT].g[i]),
            .den (root),
            .quo (m_lane[i])
        );
    end

    // residual tail
    pfar_pkg::tail_t tl0;
    pfar_pkg::tail_t tl_reg [1:pfar_pkg::TAIL_STAGES];

    always_comb
    begin
        tl0     = '0;
        tl0.c   = itm_reg[S_M].c;
        tl0.n   = itm_reg[S_M].n;
        tl0.cx  = itm_reg[S_M].cx;
        tl0.g   = itm_reg[S_M].g;
        tl0.nrm = nrm_reg[DIV_LAT-1];
        tl0.m   = m_lane;
    end

    for (genvar k = 1; k <= pfar_pkg::TAIL_STAGES; k++)
    begin : g_tail
        if (k == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                    tl_reg[k] <= tail_step(k, tl0, eps_reg, dtmn_reg, mcdt_reg);
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (adv)
                    tl_reg[k] <= tail_step(k, tl_reg[k-1], eps_reg, dtmn_reg, mcdt_reg);
            end
        end
    end

    assign conc_value_term  = tl_reg[pfar_pkg::TAIL_STAGES].c;
    assign conc_flux_x      = tl_reg[pfar_pkg::TAIL_STAGES].cfo[0];
    assign conc_flux_y      = tl_reg[pfar_pkg::TAIL_STAGES].cfo[1];
    assign conc_flux_z      = tl_reg[pfar_pkg::TAIL_STAGES].cfo[2];
    assign order_value_term = tl_reg[pfar_pkg::TAIL_STAGES].ov;
    assign order_flux_x     = tl_reg[pfar_pkg::TAIL_STAGES].of[0];
    assign order_flux_y     = tl_reg[pfar_pkg::TAIL_STAGES].of[1];
    assign order_flux_z     = tl_reg[pfar_pkg::TAIL_STAGES].of[2];

    // checks
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(v_reg))
        else $error("pipeline valid bits moved during output stall");

    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[S_RT] && root == 32'd0) |->
            (itm_reg[S_RT].g[0] == 32'd0 && itm_reg[S_RT].g[1] == 32'd0
             && itm_reg[S_RT].g[2] == 32'd0))
        else $error("zero gradient norm for nonzero gradient");

    a_unit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_M] |->
            (s64(m_lane[0]) <= ONE && s64(m_lane[0]) >= -ONE
             && s64(m_lane[1]) <= ONE && s64(m_lane[1]) >= -ONE
             && s64(m_lane[2]) <= ONE && s64(m_lane[2]) >= -ONE))
        else $error("normal component exceeds one");

    a_flat_z: assert property (@(posedge clk) disable iff (!rst_n)
        (DIMENSION == 2 && out_valid) |-> (conc_flux_z == 32'd0 && order_flux_z == 32'd0))
        else $error("z flux nonzero in 2-D build");

endmodule

/* tb/phase_field_anisotropic_residual_core_tb.sv */
// Self-checking testbench for the phase-field residual core: directed table, then random items.
module phase_field_anisotropic_residual_core_tb;

    localparam int DIM   = pfar_pkg::DIMENSION_DEF;
    localparam int FB    = pfar_pkg::FRACTION_BITS_DEF;
    localparam int AW    = pfar_pkg::CFG_ADDR_W;
    localparam int LAT   = 49 + FB;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] c;
        logic [2:0][31:0] cx;
        logic [31:0] n;
        logic [2:0][31:0] g;
    } point_t;

    typedef struct packed {
        logic [31:0] cv;
        logic [2:0][31:0] cf;
        logic [31:0] nv;
        logic [2:0][31:0] nf;
    } resid_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] conc = '0, conc_grad_x = '0, conc_grad_y = '0, conc_grad_z = '0;
    logic [31:0] order = '0, order_grad_x = '0, order_grad_y = '0, order_grad_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] conc_value_term, conc_flux_x, conc_flux_y, conc_flux_z;
    logic [31:0] order_value_term, order_flux_x, order_flux_y, order_flux_z;

    phase_field_anisotropic_residual_core uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    longint eps_r, mc_r, mn_r, dt_r;
    resid_t expected_q[$];
    bit failed = 1'b0;
    longint cycles = 0;
    bit stim_done = 1'b0;
    string cf_name [3] = '{"conc_flux_x", "conc_flux_y", "conc_flux_z"};
    string nf_name [3] = '{"order_flux_x", "order_flux_y", "order_flux_z"};

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fmul(longint a, longint b);
        return sat32((a * b) >>> FB);
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic resid_t residual(point_t p);
        resid_t o;
        longint c, n, cx[3], g[3], m[3], dg[3];
        longint cm1, fa, fbv, fac, fbc, n2, n3, h, hn, w, dtmn, mcdt;
        longint normw, norms, s4, gam, dot, t, m2, a, an, cf;
        longint unsigned ss;
        c = sx(p.c);
        n = sx(p.n);
        for (int i = 0; i < 3; i++)
        begin
            cx[i] = (i < DIM) ? sx(p.cx[i]) : 0;
            g[i]  = (i < DIM) ? sx(p.g[i]) : 0;
        end
        cm1 = sat32(c - ONE);
        fa  = fmul(c, c) >>> 5;
        fbv = fmul(cm1, cm1) >>> 5;
        fac = c >>> 4;
        fbc = cm1 >>> 4;
        n2  = fmul(n, n);
        n3  = fmul(n2, n);
        h   = sat32(3 * n2 - 2 * n3);
        hn  = sat32(6 * (n - n2));
        ss = 0;
        for (int i = 0; i < 3; i++) ss += longint'(g[i] * g[i]);
        normw = isqrt(ss);
        norms = sat32(normw);
        for (int i = 0; i < 3; i++) m[i] = (normw != 0) ? (g[i] * ONE) / normw : 0;
        s4 = 0;
        for (int i = 0; i < 3; i++)
        begin
            m2 = fmul(m[i], m[i]);
            s4 += fmul(m2, m2);
            dg[i] = sat32(16 * fmul(eps_r, fmul(m2, m[i])));
        end
        t = sat32(4 * s4 - 3 * ONE);
        gam = sat32(ONE + fmul(eps_r, t));
        dot = 0;
        for (int i = 0; i < 3; i++) dot += fmul(m[i], dg[i]);
        dot = sat32(dot);
        dtmn = fmul(dt_r, mn_r);
        mcdt = fmul(mc_r, dt_r);
        w = sat32(fmul(sat32(ONE - h), ONE >>> 4) + fmul(h, ONE >>> 4));
        o.cv = c[31:0];
        o.nv = 32'(sat32(n - fmul(fmul(dtmn, sat32(fbv - fa)), hn)));
        for (int i = 0; i < 3; i++)
        begin
            cf = sat32(fmul(cx[i], w) + fmul(fmul(g[i], hn), sat32(fbc - fac)));
            a  = sat32(dg[i] - fmul(m[i], dot));
            an = fmul(gam, sat32(fmul(a, norms) + fmul(gam, g[i])));
            o.cf[i] = (i < DIM) ? 32'(sat32(-fmul(mcdt, cf))) : 32'd0;
            o.nf[i] = (i < DIM) ? 32'(sat32(-fmul(dtmn, an))) : 32'd0;
        end
        return o;
    endfunction

    task automatic write_reg(pfar_pkg::cfg_reg_t r, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= AW'(4 * int'(r)); pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            pfar_pkg::REG_ANISO: eps_r = sx(v);
            pfar_pkg::REG_CMOB:  mc_r = longint'(v[30:0]);
            pfar_pkg::REG_NMOB:  mn_r = longint'(v[30:0]);
            pfar_pkg::REG_DT:    dt_r = longint'(v[30:0]);
            default:             eps_r = eps_r;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
    endtask

    task automatic send(point_t p);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {conc, conc_grad_x, conc_grad_y, conc_grad_z} <= {p.c, p.cx[0], p.cx[1], p.cx[2]};
        {order, order_grad_x, order_grad_y, order_grad_z} <= {p.n, p.g[0], p.g[1], p.g[2]};
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(residual(p));
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return 32'(int'($urandom_range(0, 32'h0300_0000)) - 32'sh0180_0000);
            default: return 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    function automatic point_t rnd_point();
        point_t p;
        p.c = rnd_word(); p.n = rnd_word();
        for (int i = 0; i < 3; i++)
        begin
            p.cx[i] = rnd_word();
            p.g[i] = ($urandom_range(0, 9) == 0) ? 32'd0 : rnd_word();
        end
        if ($urandom_range(0, 15) == 0) p.g = '0;
        return p;
    endfunction

    // directed points: c, n, cx (all three), g (x, y, z)
    localparam int NDIR = 14;
    logic [31:0] dir_tab [NDIR][6] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, 32'h0},
        '{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h0},
        '{32'h0080_0000, 32'h0080_0000, 32'h0040_0000, 32'h0100_0000, 32'h0, 32'h0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000},
        '{32'hFF00_0000, 32'h0180_0000, 32'hFFC0_0000, 32'h0, 32'h0100_0000, 32'h0},
        '{32'h0040_0000, 32'h0020_0000, 32'h0010_0000, 32'h0, 32'h0, 32'hFF00_0000},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
          32'h0000_0001},
        '{32'h0200_0000, 32'hFE00_0000, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000,
          32'h0080_0000},
        '{32'hC000_0000, 32'h4000_0000, 32'h1234_5678, 32'h0300_0000, 32'hFD00_0000,
          32'h0100_0000},
        '{32'h0155_5555, 32'h00AA_AAAA, 32'hF000_0000, 32'h8000_0000, 32'h0, 32'h0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
          32'h5555_5555},
        '{32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 32'h0010_0000, 32'h0020_0000,
          32'h0030_0000},
        '{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000}
    };

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("phase_field_anisotropic_residual_core_tb: FAIL");
            $finish;
        end
    end

    // result side: random stall per item, checks against the oldest expectation
    int stall = 0;
    always @(posedge clk)
    begin
        resid_t got, exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.cv = conc_value_term; got.nv = order_value_term;
                got.cf = {conc_flux_z, conc_flux_y, conc_flux_x};
                got.nf = {order_flux_z, order_flux_y, order_flux_x};
                if (expected_q.size() == 0)
                begin
                    $error("unexpected item");
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.cv !== exp_r.cv)
                    begin $error("conc_value_term exp %h got %h", exp_r.cv, got.cv); failed = 1'b1; end
                    if (got.nv !== exp_r.nv)
                    begin $error("order_value_term exp %h got %h", exp_r.nv, got.nv); failed = 1'b1; end
                    for (int i = 0; i < 3; i++)
                    begin
                        if (got.cf[i] !== exp_r.cf[i])
                        begin
                            $error("%s exp %h got %h", cf_name[i], exp_r.cf[i], got.cf[i]);
                            failed = 1'b1;
                        end
                        if (got.nf[i] !== exp_r.nf[i])
                        begin
                            $error("%s exp %h got %h", nf_name[i], exp_r.nf[i], got.nf[i]);
                            failed = 1'b1;
                        end
                    end
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                out_ready <= (stall == 0);
            end
            else if (stall > 0)
            begin
                stall = stall - 1;
                out_ready <= (stall == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        point_t p;
        logic [31:0] eps_set [6] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0040_0000,
                                     32'hFFC0_0000, 32'h0100_0000};
        logic [31:0] mob_set [6] = '{32'h0100_0000, 32'h7FFF_FFFF, 32'h0, 32'h0080_0000,
                                     32'hFFFF_FFFF, 32'h0400_0000};
        logic [31:0] dt_set [6]  = '{32'd1677, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000,
                                     32'h8100_0000, 32'h0010_0000};
        eps_r = 0; mc_r = 64'd16777216; mn_r = 64'd16777216; dt_r = 1677;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset defaults: zero point gives all-zero result
        for (int k = 0; k < NDIR; k++)
        begin
            p.c = dir_tab[k][0]; p.n = dir_tab[k][1];
            p.cx = {dir_tab[k][2], dir_tab[k][2], dir_tab[k][2]};
            p.g = {dir_tab[k][5], dir_tab[k][4], dir_tab[k][3]};
            send(p);
            if (k == 0 && residual(p) !== resid_t'(0))
            begin
                $error("zero point expected all-zero result");
                failed = 1'b1;
            end
        end
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_reg(pfar_pkg::REG_ANISO, eps_set[ph]);
                write_reg(pfar_pkg::REG_CMOB, mob_set[ph]);
                write_reg(pfar_pkg::REG_NMOB, mob_set[5 - ph]);
                write_reg(pfar_pkg::REG_DT, dt_set[ph]);
            end
            for (int k = 0; k < 160; k++) send(rnd_point());
        end
        drain();
        if (failed)
            $display("phase_field_anisotropic_residual_core_tb: FAIL");
        else
            $display("phase_field_anisotropic_residual_core_tb: PASS");
        $finish;
    end
endmodule
